// ----- design/avt_pkg.sv -----
`default_nettype none

package avt_pkg;

  // Field widths
  localparam int POS_W   = 16;                 // Q12.4 position
  localparam int DIFF_W  = POS_W + 1;          // exact difference
  localparam int SPEED_W = 16;                 // Q0.16 speed
  localparam int VEL_W   = 17;                 // signed Q0.16 velocity

  // CORDIC datapath: |d| * 2^14 grows by up to K * sqrt(2), rotation by K
  localparam int FRAC_SHIFT = 14;
  localparam int CW         = 34;

  // 1/K in Q0.32 for the rotation start vector
  localparam int GAIN_W = 32;
  localparam logic [GAIN_W-1:0] INV_GAIN = 32'h9B74EDA8;
  localparam int PROD_W = SPEED_W + GAIN_W;

  // Rounding of the final components
  localparam int RND_SHIFT = 16;
  localparam int RND_W     = CW + 1;

  // Bus widths
  localparam int IN_DATA_W  = 4 * POS_W;
  localparam int OUT_DATA_W = ((2 * VEL_W + 7) / 8) * 8;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic dy_zero;
  } flags_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    flags_t               flags;
    logic [SPEED_W-1:0]   speed;
  } cordic_t;

endpackage

`default_nettype wire

// ----- design/avt_front.sv -----
`default_nettype none

// Entry stage: differences, magnitudes, case flags and the 1/K scaled speed.
module avt_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [avt_pkg::POS_W-1:0]  source_x,
  input  wire logic signed [avt_pkg::POS_W-1:0]  source_y,
  input  wire logic signed [avt_pkg::POS_W-1:0]  target_x,
  input  wire logic signed [avt_pkg::POS_W-1:0]  target_y,
  input  wire logic [avt_pkg::SPEED_W-1:0]       speed,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output avt_pkg::cordic_t                       out_data
);
  import avt_pkg::*;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        mag_x;
  logic [DIFF_W-1:0]        mag_y;
  logic [PROD_W-1:0]        prod;
  cordic_t                  data_next;

  // Exact differences and magnitudes
  always_comb begin
    dx    = DIFF_W'(target_x) - DIFF_W'(source_x);
    dy    = DIFF_W'(target_y) - DIFF_W'(source_y);
    mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    prod  = PROD_W'(speed) * PROD_W'(INV_GAIN);

    data_next.ax            = CW'({mag_x, {FRAC_SHIFT{1'b0}}});
    data_next.ay            = CW'({mag_y, {FRAC_SHIFT{1'b0}}});
    data_next.rx            = CW'(prod[PROD_W-1:RND_SHIFT]);
    data_next.ry            = '0;
    data_next.flags.dx_neg  = dx[DIFF_W-1];
    data_next.flags.dy_neg  = dy[DIFF_W-1];
    data_next.flags.dx_zero = (dx == '0);
    data_next.flags.dy_zero = (dy == '0);
    data_next.speed         = speed;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/avt_cordic_stage.sv -----
`default_nettype none

// One CORDIC iteration: vectoring on (ax, ay) steers rotation of (rx, ry).
module avt_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire avt_pkg::cordic_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output avt_pkg::cordic_t     out_data
);
  import avt_pkg::*;

  logic signed [CW-1:0] sax;
  logic signed [CW-1:0] say;
  logic signed [CW-1:0] srx;
  logic signed [CW-1:0] sry;
  cordic_t              data_next;

  // Rotate down while ay is zero or above, up otherwise
  always_comb begin
    sax       = in_data.ax >>> SHIFT;
    say       = in_data.ay >>> SHIFT;
    srx       = in_data.rx >>> SHIFT;
    sry       = in_data.ry >>> SHIFT;
    data_next = in_data;
    if (!in_data.ay[CW-1]) begin
      data_next.ax = in_data.ax + say;
      data_next.ay = in_data.ay - sax;
      data_next.rx = in_data.rx - sry;
      data_next.ry = in_data.ry + srx;
    end else begin
      data_next.ax = in_data.ax - say;
      data_next.ay = in_data.ay + sax;
      data_next.rx = in_data.rx + sry;
      data_next.ry = in_data.ry - srx;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/avt_back.sv -----
`default_nettype none

// Output stage: round, clamp, apply signs and special cases; holds the result word.
module avt_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire avt_pkg::cordic_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [avt_pkg::VEL_W-1:0]       velocity_x,
  output logic signed [avt_pkg::VEL_W-1:0]       velocity_y
);
  import avt_pkg::*;

  localparam int MAG_W = VEL_W - 1;
  localparam int R_W   = RND_W - RND_SHIFT;

  logic signed [RND_W-1:0] sum_x;
  logic signed [RND_W-1:0] sum_y;
  logic signed [R_W-1:0]   r_x;
  logic signed [R_W-1:0]   r_y;
  logic [MAG_W-1:0]        mag_x;
  logic [MAG_W-1:0]        mag_y;
  logic signed [VEL_W-1:0] vx_next;
  logic signed [VEL_W-1:0] vy_next;
  logic signed [VEL_W-1:0] sp;

  // Round half up, clamp to 0..max, then sign
  always_comb begin
    sum_x = RND_W'(in_data.rx) + RND_W'(1 << (RND_SHIFT - 1));
    sum_y = RND_W'(in_data.ry) + RND_W'(1 << (RND_SHIFT - 1));
    r_x   = R_W'(sum_x >>> RND_SHIFT);
    r_y   = R_W'(sum_y >>> RND_SHIFT);

    if (r_x[R_W-1])                     mag_x = '0;
    else if (r_x[R_W-2:MAG_W] != '0)    mag_x = '1;
    else                                mag_x = r_x[MAG_W-1:0];
    if (r_y[R_W-1])                     mag_y = '0;
    else if (r_y[R_W-2:MAG_W] != '0)    mag_y = '1;
    else                                mag_y = r_y[MAG_W-1:0];

    sp = VEL_W'(in_data.speed);
    if (in_data.flags.dx_zero && in_data.flags.dy_zero) begin
      vx_next = sp;
      vy_next = '0;
    end else if (in_data.flags.dx_zero) begin
      vx_next = '0;
      vy_next = in_data.flags.dy_neg ? -sp : sp;
    end else begin
      vx_next = in_data.flags.dx_neg ? -VEL_W'(mag_x) : VEL_W'(mag_x);
      vy_next = in_data.flags.dy_neg ? -VEL_W'(mag_y) : VEL_W'(mag_y);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      velocity_x <= vx_next;
      velocity_y <= vy_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/aim_velocity_toward_target.sv -----
`default_nettype none

// Aim velocity toward a target. Each input word carries a source and a target
// point (signed Q12.4); the result word is a velocity of magnitude speed
// (unsigned Q0.16, set through the cfg channel) pointing from source to
// target. Equal points give (speed, 0); a vertical line gives (0, +/-speed).
// The datapath is a pipelined CORDIC with one register stage per iteration
// between registered entry and output stages. A new word is accepted every
// cycle until m_tready backpressure fills every stage. Each stage has its own
// valid bit and fills bubbles under backpressure, so input keeps flowing while
// a result waits on m_tready. Speed is sampled as a word enters the pipeline.
module aim_velocity_toward_target #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // cfg: speed register
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [avt_pkg::SPEED_W-1:0]       cfg_data,
  // s_tdata: source_x[15:0], source_y[31:16], target_x[47:32], target_y[63:48]
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [avt_pkg::IN_DATA_W-1:0]     s_tdata,
  // m_tdata: velocity_x[16:0], velocity_y[33:17], zero pad [39:34]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [avt_pkg::OUT_DATA_W-1:0]         m_tdata
);
  import avt_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic [SPEED_W-1:0]       speed;
  logic                     st_valid [N+1];
  logic                     st_ready [N+1];
  cordic_t                  st_data  [N+1];
  logic signed [VEL_W-1:0]  velocity_x;
  logic signed [VEL_W-1:0]  velocity_y;

  // Speed register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      speed <= cfg_data;
    end
  end

  avt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .source_x  (s_tdata[POS_W-1:0]),
    .source_y  (s_tdata[2*POS_W-1:POS_W]),
    .target_x  (s_tdata[3*POS_W-1:2*POS_W]),
    .target_y  (s_tdata[4*POS_W-1:3*POS_W]),
    .speed     (speed),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0])
  );

  // CORDIC iterations, one stage each
  for (genvar i = 0; i < N; i++) begin : g_iter
    avt_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .in_data   (st_data[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .out_data  (st_data[i+1])
    );
  end

  avt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid[N]),
    .in_ready   (st_ready[N]),
    .in_data    (st_data[N]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .velocity_x (velocity_x),
    .velocity_y (velocity_y)
  );

  assign m_tdata = OUT_DATA_W'({velocity_y, velocity_x});

  // Entry stage empty means the input side must be open
  assert property (@(posedge clk) disable iff (rst) !st_valid[0] |-> s_tready)
    else $error("input stalled with empty entry stage");

  // Clamped magnitude never reaches the most negative code
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (velocity_x != -(VEL_W'(1) <<< (VEL_W - 1))))
    else $error("velocity_x out of range");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (velocity_y != -(VEL_W'(1) <<< (VEL_W - 1))))
    else $error("velocity_y out of range");

endmodule

`default_nettype wire

// ----- tb/sv/aim_velocity_checker.sv -----
module aim_velocity_checker #(
  parameter int ITERS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [avt_pkg::SPEED_W-1:0]      cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [avt_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [avt_pkg::OUT_DATA_W-1:0]   m_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = avt_pkg::VEL_W;
  // 1/K in Q0.32, start of the rotation vector
  localparam logic [31:0] ONE_OVER_GAIN = 32'h9B74EDA8;
  localparam int MAX_PRINTS = 25;

  typedef struct packed {
    logic [VW-1:0] vx;
    logic [VW-1:0] vy;
  } velocity_t;

  velocity_t                   velocity_q[$];
  logic [avt_pkg::SPEED_W-1:0] speed_reg;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // round half up from 16 extra fraction bits, clamp to the unsigned range
  function automatic longint round_clamp(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r;
  endfunction

  // velocity of magnitude spd pointing from (sx, sy) toward (tx, ty)
  function automatic velocity_t predict_velocity(logic signed [15:0] sx,
                                                 logic signed [15:0] sy,
                                                 logic signed [15:0] tx,
                                                 logic signed [15:0] ty,
                                                 logic [15:0] spd);
    longint    dx, dy, ax, ay, rx, ry, sax, say, srx, sry, vx, vy;
    int        n;
    velocity_t v;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    if (dx == 0 && dy == 0) begin
      vx = spd;
      vy = 0;
    end else if (dx == 0) begin
      vx = 0;
      vy = (dy < 0) ? -longint'(spd) : longint'(spd);
    end else begin
      ax = ((dx < 0) ? -dx : dx) * 16384;
      ay = ((dy < 0) ? -dy : dy) * 16384;
      rx = longint'((64'(spd) * 64'(ONE_OVER_GAIN)) >> 16);
      ry = 0;
      n  = (ITERS > 60) ? 60 : ITERS;
      // vectoring on (ax, ay) steers the rotation of (rx, ry)
      for (int i = 0; i < n; i++) begin
        sax = ax >>> i;
        say = ay >>> i;
        srx = rx >>> i;
        sry = ry >>> i;
        if (ay >= 0) begin
          ax = ax + say;
          ay = ay - sax;
          rx = rx - sry;
          ry = ry + srx;
        end else begin
          ax = ax - say;
          ay = ay + sax;
          rx = rx + sry;
          ry = ry - srx;
        end
      end
      vx = round_clamp(rx);
      vy = round_clamp(ry);
      if (dx < 0) vx = -vx;
      if (dy < 0) vy = -vy;
    end
    v.vx = vx[VW-1:0];
    v.vy = vy[VW-1:0];
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    velocity_t want;
    logic [VW-1:0] got_vx, got_vy;
    logic [avt_pkg::OUT_DATA_W-2*VW-1:0] got_pad;
    if (rst) begin
      speed_reg <= '0;
    end else begin
      // expectation is taken with the speed in force when the word enters
      if (s_tvalid && s_tready)
        velocity_q.push_back(predict_velocity(s_tdata[15:0], s_tdata[31:16],
                                              s_tdata[47:32], s_tdata[63:48],
                                              speed_reg));
      if (cfg_valid && cfg_ready)
        speed_reg <= cfg_data;
      if (m_tvalid && m_tready) begin
        got_vx  = m_tdata[VW-1:0];
        got_vy  = m_tdata[2*VW-1:VW];
        got_pad = m_tdata[avt_pkg::OUT_DATA_W-1:2*VW];
        if (velocity_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_tdata));
        end else begin
          want = velocity_q.pop_front();
          checked++;
          if (got_vx !== want.vx)
            report_mismatch($sformatf("velocity_x got %0d want %0d (word %0d)",
                                      $signed(got_vx), $signed(want.vx), checked));
          if (got_vy !== want.vy)
            report_mismatch($sformatf("velocity_y got %0d want %0d (word %0d)",
                                      $signed(got_vy), $signed(want.vy), checked));
          if (got_pad !== '0)
            report_mismatch($sformatf("pad bits not zero: %h (word %0d)",
                                      got_pad, checked));
        end
      end
    end
    pending <= velocity_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_ITERS = 16;
  localparam int LATENCY      = CORDIC_ITERS + 2;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 7;
  localparam int CYCLE_LIMIT  = 300000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [avt_pkg::SPEED_W-1:0]     cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [avt_pkg::IN_DATA_W-1:0]   s_tdata = '0;  // source_x, source_y, target_x, target_y
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [avt_pkg::OUT_DATA_W-1:0]  m_tdata;       // velocity_x, velocity_y, zero pad

  int fail_count, pending, checked;
  int items_sent  = 0;
  int speeds_used = 1;
  int burst_left  = 0;
  bit no_gaps     = 1'b0;
  int hold_asks   = 0;
  int hold_served = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  aim_velocity_toward_target #(
    .CORDIC_ITERATIONS(CORDIC_ITERS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  aim_velocity_checker #(
    .ITERS(CORDIC_ITERS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  // one word per handshake; bursts with random gaps in between
  task automatic send_word(input logic [63:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0 && !no_gaps) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_points(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] tx, input logic [15:0] ty);
    send_word({ty, tx, sy, sx});
  endtask

  // stop offering and wait until every expected word has come back
  task automatic drain_results();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_speed(input logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    speeds_used++;
  endtask

  function automatic logic [15:0] extreme_coord();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // mix of arbitrary points, near points, axis lines, equal points,
  // extreme coordinates and diagonals
  function automatic logic [63:0] random_aim();
    logic [15:0] sx, sy, tx, ty, d;
    sx = 16'($urandom);
    sy = 16'($urandom);
    tx = 16'($urandom);
    ty = 16'($urandom);
    case ($urandom_range(0, 10))
      4, 5: begin
        tx = sx + 16'($urandom_range(0, 128)) - 16'd64;
        ty = sy + 16'($urandom_range(0, 128)) - 16'd64;
      end
      6: tx = sx;
      7: ty = sy;
      8: begin
        tx = sx;
        ty = sy;
      end
      9: begin
        sx = extreme_coord();
        sy = extreme_coord();
        tx = extreme_coord();
        ty = extreme_coord();
      end
      10: begin
        d  = 16'($urandom_range(1, 2000));
        tx = $urandom_range(0, 1) ? sx + d : sx - d;
        ty = $urandom_range(0, 1) ? sy + d : sy - d;
      end
      default: ;
    endcase
    return {ty, tx, sy, sx};
  endfunction

  // receiver: segments of always-ready, random and periodic stalls,
  // plus a long hold-off whenever the stimulus asks for one
  initial begin
    int mode, seg, k;
    forever begin
      if (hold_asks != hold_served) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(16, 160);
        k    = $urandom_range(2, 6);
        for (int j = 0; j < seg; j++) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= ((j % k) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [15:0] phase_speed[NUM_PHASES];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // speed left at its reset value of zero
    send_points(0, 0, 0, 0);
    send_points(100, -200, 3000, 5000);
    send_points(0, 0, 0, -7);

    // directed corners at full speed
    write_speed(16'hFFFF);
    send_points(0, 0, 0, 0);
    send_points(-32768, -32768, -32768, -32768);
    send_points(5, 5, 5, 6);
    send_points(5, 5, 5, 4);
    send_points(0, -32768, 0, 32767);
    send_points(0, 32767, 0, -32768);
    send_points(-32768, 0, 32767, 0);
    send_points(32767, 0, -32768, 0);
    send_points(0, 0, 1, 0);
    send_points(0, 0, -1, 0);
    send_points(0, 0, 100, 100);
    send_points(0, 0, -100, 100);
    send_points(0, 0, 100, -100);
    send_points(0, 0, -100, -100);
    send_points(-32768, -32768, 32767, 32767);
    send_points(32767, 32767, -32768, -32768);
    send_points(0, -32768, 1, 32767);
    send_points(-32768, 0, 32767, 1);
    send_points(0, 32767, -1, -32768);

    // random phases, each under its own speed
    phase_speed[0] = 16'hFFFF;
    phase_speed[1] = 16'h0000;
    phase_speed[2] = 16'h0001;
    phase_speed[3] = 16'h8000;
    phase_speed[4] = 16'($urandom);
    phase_speed[5] = 16'h7FFF;
    phase_speed[6] = 16'($urandom);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_speed(phase_speed[p]);
      no_gaps = (p == 2 || p == 5);
      // long output hold while input keeps coming
      if (p == 2) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && p % 2 == 1) drain_results();
        send_word(random_aim());
      end
    end

    drain_results();
    repeat (4 * LATENCY) @(posedge clk);

    $display("Run covered %0d aim requests under %0d speed settings (0, 1, 0x7FFF,",
             items_sent, speeds_used);
    $display("0x8000, 0xFFFF, random) with bursts, stalls and a long hold; %0d words checked",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
